// ----- sv/bmrv_pkg.sv -----
// shared types, codes and constants for the block motion running variance unit
// no dependencies
`timescale 1ns / 1ps

package bmrv_pkg;

  localparam int unsigned BLK_W      = 10;
  localparam int unsigned NUM_BLOCKS = 1024;
  localparam int unsigned SAD_W      = 16;
  localparam int unsigned SQ_W       = 2 * SAD_W;
  localparam int unsigned VAR_W      = 48;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned FC_W       = 5;
  localparam int unsigned WARMUP_FRAMES = 30;

  localparam logic [FC_W-1:0]  FC_MAX       = 5'd31;
  localparam logic [CFG_W-1:0] RHO_RST      = 16'd3277;
  localparam logic [CFG_W-1:0] INIT_VAR_RST = 16'd3277;
  localparam logic [CFG_W-1:0] THR_MULT_RST = 16'd256;
  localparam logic [VAR_W-1:0] VAR_MAX      = '1;

  typedef enum logic [1:0] {
    OP_UPDATE   = 2'd0,
    OP_CLASSIFY = 2'd1,
    OP_RESTART  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RHO      = 2'd0,
    CFG_INIT_VAR = 2'd1,
    CFG_THR_MULT = 2'd2
  } cfg_idx_t;

  // what the pipeline does with an item, decided at accept
  typedef enum logic [2:0] {
    K_NONE  = 3'd0,
    K_INIT  = 3'd1,
    K_EMA   = 3'd2,
    K_HOLD  = 3'd3,
    K_CLASS = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [BLK_W-1:0]  idx;
    logic [SAD_W-1:0]  sad;
    logic              ready;
    logic              last;
  } item_t;

  typedef struct packed {
    logic [CFG_W-1:0] rho;
    logic [CFG_W-1:0] init_var;
    logic [CFG_W-1:0] thr_mult;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic              mean_en;
    logic [BLK_W-1:0]  idx;
    logic [VAR_W-1:0]  var_val;
    logic [SAD_W-1:0]  mean;
  } wr_t;

  typedef struct packed {
    logic             stats_valid;
    logic [FC_W-1:0]  frame_count;
  } status_t;

  function automatic logic is_writer(kind_t k);
    is_writer = (k == K_INIT) || (k == K_EMA);
  endfunction

  function automatic logic tests_motion(kind_t k);
    tests_motion = (k == K_EMA) || (k == K_HOLD) || (k == K_CLASS);
  endfunction

endpackage

// ----- sv/bmrv_ctrl.sv -----
// configuration registers, frame counter and stats flag; classifies each accepted beat
// depends on bmrv_pkg
`timescale 1ns / 1ps

module bmrv_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bmrv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bmrv_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          acc,
  input  logic [1:0]                    operation,
  input  logic [bmrv_pkg::BLK_W-1:0]    block_index,
  input  logic [bmrv_pkg::SAD_W-1:0]    sad_value,
  input  logic                          blink_active,
  input  logic                          last_block,
  output bmrv_pkg::cfg_t                cfg,
  output bmrv_pkg::item_t               item,
  output bmrv_pkg::status_t             status
);
  import bmrv_pkg::*;

  cfg_t            cfg_r;
  logic            sv_r, sv_nxt;
  logic [FC_W-1:0] fc_r, fc_nxt;
  logic            warm;
  kind_t           kind;

  // frame k of a run has frame_count k-1
  assign warm = ({1'b0, fc_r} + 6'd1) < 6'(WARMUP_FRAMES);

  always_comb begin
    kind = K_NONE;
    unique case (op_t'(operation))
      OP_UPDATE: begin
        if (!sv_r) begin
          kind = K_INIT;
        end else if (!blink_active || warm) begin
          kind = K_EMA;
        end else begin
          kind = K_HOLD;
        end
      end
      OP_CLASSIFY: begin
        if (sv_r) kind = K_CLASS;
      end
      default: kind = K_NONE;
    endcase
  end

  always_comb begin
    sv_nxt = sv_r;
    fc_nxt = fc_r;
    if (acc) begin
      if (op_t'(operation) == OP_UPDATE) begin
        if (last_block) sv_nxt = 1'b1;
        if (last_block && fc_r != FC_MAX) fc_nxt = fc_r + 5'd1;
      end else if (op_t'(operation) == OP_RESTART) begin
        sv_nxt = 1'b0;
        fc_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= 1'b0;
      fc_r <= '0;
    end else begin
      sv_r <= sv_nxt;
      fc_r <= fc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rho      <= RHO_RST;
      cfg_r.init_var <= INIT_VAR_RST;
      cfg_r.thr_mult <= THR_MULT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RHO:      cfg_r.rho      <= cfg_wdata;
        CFG_INIT_VAR: cfg_r.init_var <= cfg_wdata;
        CFG_THR_MULT: cfg_r.thr_mult <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg         = cfg_r;
  assign item.kind   = kind;
  assign item.idx    = block_index;
  assign item.sad    = sad_value;
  assign item.ready  = sv_r;
  assign item.last   = last_block;
  assign status.stats_valid = sv_r;
  assign status.frame_count = fc_r;

endmodule

// ----- sv/bmrv_store.sv -----
// per-block variance and mean memories, one write and one registered read per cycle while the pipeline advances
// depends on bmrv_pkg
`timescale 1ns / 1ps

module bmrv_store (
  input  logic                        clk,
  input  logic                        adv,
  input  logic [bmrv_pkg::BLK_W-1:0]  rd_idx,
  input  bmrv_pkg::wr_t               wr,
  output logic [bmrv_pkg::VAR_W-1:0]  var_rd_r,
  output logic [bmrv_pkg::SAD_W-1:0]  mean_rd_r
);
  import bmrv_pkg::*;

  logic [VAR_W-1:0] var_mem  [NUM_BLOCKS];
  logic [SAD_W-1:0] mean_mem [NUM_BLOCKS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      var_mem[wr.idx] <= wr.var_val;
      if (wr.mean_en) mean_mem[wr.idx] <= wr.mean;
    end
  end

  // read data holds while the pipeline is stalled
  always_ff @(posedge clk) begin
    if (adv) begin
      var_rd_r  <= var_mem[rd_idx];
      mean_rd_r <= mean_mem[rd_idx];
    end
  end

endmodule

// ----- sv/bmrv_pipe.sv -----
// six-stage arithmetic pipeline: square, ema partial products, ema terms, ema sum,
// threshold partial products, compare; plus output register and hazard check
// depends on bmrv_pkg
`timescale 1ns / 1ps

module bmrv_pipe (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bmrv_pkg::cfg_t              cfg,
  input  logic                        acc,
  input  bmrv_pkg::item_t             item,
  input  logic [bmrv_pkg::VAR_W-1:0]  var_rd,
  input  logic [bmrv_pkg::SAD_W-1:0]  mean_rd,
  input  logic [bmrv_pkg::BLK_W-1:0]  probe_idx,
  input  logic                        out_stall,
  output logic                        adv,
  output logic                        hazard,
  output bmrv_pkg::wr_t               wr,
  output logic                        out_valid,
  output logic                        out_motion_flag,
  output logic                        out_stats_ready,
  output logic [bmrv_pkg::BLK_W-1:0]  out_block_out,
  output logic                        out_frame_end
);
  import bmrv_pkg::*;

  logic [6:1] vld_r;
  item_t      it1_r, it2_r, it3_r, it4_r, it5_r, it6_r;

  logic [SQ_W-1:0]  sq2_r, sq3_r, sq4_r, sq5_r, sq6_r;
  logic [VAR_W-1:0] var2_r, var3_r, var4_r, var5_r;
  logic [40:0]      klo3_r, khi3_r;
  logic [VAR_W-1:0] keep4_r, add4_r;
  logic [39:0]      plo6_r, phi6_r;

  logic             out_vld_r, out_motion_r, out_ready_r, out_last_r;
  logic [BLK_W-1:0] out_blk_r;

  logic [SAD_W-1:0] diff1, x1;
  logic [SQ_W-1:0]  sq1;
  logic [16:0]      nrho;
  logic [40:0]      klo2, khi2;
  logic [48:0]      keep49;
  logic [VAR_W-1:0] add3;
  logic [48:0]      sum49;
  logic [VAR_W-1:0] ema4, varn4;
  logic [39:0]      plo5, phi5;
  logic [63:0]      prod6, sqs6;
  logic             motion6;

  assign adv = !out_vld_r || !out_stall;

  // stage 1: |mean - sad| for classify, sad otherwise, squared
  assign diff1 = (mean_rd > it1_r.sad) ? (mean_rd - it1_r.sad) : (it1_r.sad - mean_rd);
  assign x1    = (it1_r.kind == K_CLASS) ? diff1 : it1_r.sad;
  assign sq1   = {{SAD_W{1'b0}}, x1} * {{SAD_W{1'b0}}, x1};

  // stage 2: (1 - rho) * var split in two 24-bit halves
  assign nrho = 17'h10000 - {1'b0, cfg.rho};
  assign klo2 = 41'(nrho) * 41'(var2_r[23:0]);
  assign khi2 = 41'(nrho) * 41'(var2_r[47:24]);

  // stage 3: keep term >> 16, rho * sq
  assign keep49 = {khi3_r[40:0], 8'b0} + 49'(klo3_r[40:16]);
  assign add3   = 48'(cfg.rho) * 48'(sq3_r);

  // stage 4: sum, saturate, pick the value that goes back to the store
  assign sum49 = {1'b0, keep4_r} + {1'b0, add4_r};
  assign ema4  = sum49[48] ? VAR_MAX : sum49[47:0];
  always_comb begin
    case (it4_r.kind)
      K_EMA:   varn4 = ema4;
      K_INIT:  varn4 = {{(VAR_W - CFG_W){1'b0}}, cfg.init_var};
      default: varn4 = var4_r;
    endcase
  end

  // stage 5: thr_mult * var split in two halves; store write
  assign plo5 = 40'(cfg.thr_mult) * 40'(var5_r[23:0]);
  assign phi5 = 40'(cfg.thr_mult) * 40'(var5_r[47:24]);

  // the mean is only set by the first frame of a run
  assign wr.en      = adv && vld_r[5] && is_writer(it5_r.kind);
  assign wr.mean_en = (it5_r.kind == K_INIT);
  assign wr.idx     = it5_r.idx;
  assign wr.var_val = var5_r;
  assign wr.mean    = it5_r.sad;

  // stage 6: sq * 2^24 > thr_mult * var
  assign prod6   = {phi6_r, 24'b0} + 64'(plo6_r);
  assign sqs6    = {8'b0, sq6_r, 24'b0};
  assign motion6 = tests_motion(it6_r.kind) && (sqs6 > prod6);

  // an in-flight write to the same block must land before the next read
  assign hazard =
      (vld_r[1] && is_writer(it1_r.kind) && it1_r.idx == probe_idx) ||
      (vld_r[2] && is_writer(it2_r.kind) && it2_r.idx == probe_idx) ||
      (vld_r[3] && is_writer(it3_r.kind) && it3_r.idx == probe_idx) ||
      (vld_r[4] && is_writer(it4_r.kind) && it4_r.idx == probe_idx) ||
      (vld_r[5] && is_writer(it5_r.kind) && it5_r.idx == probe_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r     <= {vld_r[5:1], acc};
      out_vld_r <= vld_r[6];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it1_r   <= item;
      it2_r   <= it1_r;
      sq2_r   <= sq1;
      var2_r  <= var_rd;
      it3_r   <= it2_r;
      sq3_r   <= sq2_r;
      var3_r  <= var2_r;
      klo3_r  <= klo2;
      khi3_r  <= khi2;
      it4_r   <= it3_r;
      sq4_r   <= sq3_r;
      var4_r  <= var3_r;
      keep4_r <= keep49[47:0];
      add4_r  <= add3;
      it5_r   <= it4_r;
      sq5_r   <= sq4_r;
      var5_r  <= varn4;
      it6_r   <= it5_r;
      sq6_r   <= sq5_r;
      plo6_r  <= plo5;
      phi6_r  <= phi5;
      out_motion_r <= motion6;
      out_ready_r  <= it6_r.ready;
      out_blk_r    <= it6_r.idx;
      out_last_r   <= it6_r.last;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_motion_flag = out_motion_r;
  assign out_stats_ready = out_ready_r;
  assign out_block_out   = out_blk_r;
  assign out_frame_end   = out_last_r;

endmodule

// ----- sv/block_motion_running_variance_unit.sv -----
// an accepted beat passes through pipeline stages 1 to 6 and then the output register
// throughput: one beat per cycle unless out_stall holds it; a beat whose block still has
// a variance write in flight (read-modify-write through the per-block store) waits for it
// reset: synchronous active-low rst_n clears pipeline valids, frame count and stats flag
// and loads the config reset values; the variance and mean stores are not cleared
`timescale 1ns / 1ps

module block_motion_running_variance_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bmrv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bmrv_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_operation,
  input  logic [bmrv_pkg::BLK_W-1:0]     in_block_index,
  input  logic [bmrv_pkg::SAD_W-1:0]     in_sad_value,
  input  logic                           in_blink_active,
  input  logic                           in_last_block,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_motion_flag,
  output logic                           out_stats_ready,
  output logic [bmrv_pkg::BLK_W-1:0]     out_block_out,
  output logic                           out_frame_end
);
  import bmrv_pkg::*;

  cfg_t             cfg;
  item_t            item;
  status_t          status;
  wr_t              wr;
  logic             adv, hazard, in_acc;
  logic [VAR_W-1:0] var_rd;
  logic [SAD_W-1:0] mean_rd;

  assign in_stall = !adv || hazard;
  assign in_acc   = in_valid && !in_stall;

  bmrv_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .acc          (in_acc),
    .operation    (in_operation),
    .block_index  (in_block_index),
    .sad_value    (in_sad_value),
    .blink_active (in_blink_active),
    .last_block   (in_last_block),
    .cfg          (cfg),
    .item         (item),
    .status       (status)
  );

  bmrv_store u_store (
    .clk       (clk),
    .adv       (adv),
    .rd_idx    (in_block_index),
    .wr        (wr),
    .var_rd_r  (var_rd),
    .mean_rd_r (mean_rd)
  );

  bmrv_pipe u_pipe (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .acc             (in_acc),
    .item            (item),
    .var_rd          (var_rd),
    .mean_rd         (mean_rd),
    .probe_idx       (in_block_index),
    .out_stall       (out_stall),
    .adv             (adv),
    .hazard          (hazard),
    .wr              (wr),
    .out_valid       (out_valid),
    .out_motion_flag (out_motion_flag),
    .out_stats_ready (out_stats_ready),
    .out_block_out   (out_block_out),
    .out_frame_end   (out_frame_end)
  );

  // a new beat never reads the block being written back in the same cycle
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && wr.en) |-> (wr.idx != in_block_index))
    else $error("read of a block with a write landing in the same cycle");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_operation == OP_RESTART) |=>
      (!status.stats_valid && status.frame_count == '0))
    else $error("restart did not clear statistics");

  a_fc_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && in_operation == OP_RESTART) |=>
      (status.frame_count >= $past(status.frame_count)))
    else $error("frame count went down without restart");

endmodule

// ----- dv/testbench.sv -----
// self-checking testbench for block_motion_running_variance_unit
// depends on bmrv_pkg and the unit; a clocked driver feeds beats and a monitor checks every result beat
`timescale 1ns / 1ps

module testbench;
  import bmrv_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         PHASES       = 6;
  localparam int         PHASE_ITEMS  = 172;
  localparam int         DRAIN_CYCLES = 16;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         MAX_REPORTS  = 10;

  typedef struct packed {
    logic [1:0]       op;
    logic [BLK_W-1:0] blk;
    logic [SAD_W-1:0] sad;
    logic             blink;
    logic             last;
    logic [2:0]       gap;
  } sad_beat_t;

  typedef struct packed {
    logic             motion;
    logic             ready;
    logic [BLK_W-1:0] blk;
    logic             last;
  } mask_beat_t;

  logic                 clk;
  logic                 rst_n           = 1'b0;
  logic                 cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index       = '0;
  logic [CFG_W-1:0]     cfg_wdata       = '0;
  logic                 in_valid        = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_operation    = '0;
  logic [BLK_W-1:0]     in_block_index  = '0;
  logic [SAD_W-1:0]     in_sad_value    = '0;
  logic                 in_blink_active = 1'b0;
  logic                 in_last_block   = 1'b0;
  logic                 out_valid;
  logic                 out_stall       = 1'b0;
  logic                 out_motion_flag;
  logic                 out_stats_ready;
  logic [BLK_W-1:0]     out_block_out;
  logic                 out_frame_end;

  block_motion_running_variance_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_block_index  (in_block_index),
    .in_sad_value    (in_sad_value),
    .in_blink_active (in_blink_active),
    .in_last_block   (in_last_block),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_motion_flag (out_motion_flag),
    .out_stats_ready (out_stats_ready),
    .out_block_out   (out_block_out),
    .out_frame_end   (out_frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // running statistics mirror
  logic [VAR_W-1:0] var_mem [NUM_BLOCKS];
  logic [SAD_W-1:0] mean_mem [NUM_BLOCKS];
  logic [FC_W-1:0]  frames_done  = '0;
  logic             stats_live   = 1'b0;
  logic [CFG_W-1:0] rho_q16      = RHO_RST;
  logic [CFG_W-1:0] init_var_q16 = INIT_VAR_RST;
  logic [CFG_W-1:0] vfac_q8      = THR_MULT_RST;

  sad_beat_t  sad_q[$];
  mask_beat_t mask_q[$];

  // stimulus-side view of which blocks hold statistics
  logic             gen_live = 1'b0;
  bit               gen_written [NUM_BLOCKS];
  logic [BLK_W-1:0] written_list[$];
  int               gen_count = 0;
  bit               src_burst = 1'b0;

  bit        beat_taken = 1'b0;
  bit        out_taken  = 1'b0;
  int        gap_wait   = 0;
  int        stall_left = 0;
  bit        sink_burst = 1'b0;
  sad_beat_t drv_beat;
  mask_beat_t got_mask, want_mask;

  int fail_count = 0;
  int n_update = 0, n_classify = 0, n_restart = 0, n_ignored = 0;
  int n_motion = 0, n_frozen = 0, max_frames = 0;
  int cycle_cnt = 0;

  function automatic logic [VAR_W-1:0] ema_step(logic [63:0] vr, logic [63:0] sq);
    logic [64:0] keep, add, sum;
    keep = 65'd65536 - 65'(rho_q16);
    keep = (keep * 65'(vr)) >> 16;
    add  = 65'(rho_q16) * 65'(sq);
    sum  = keep + add;
    return (sum > 65'(VAR_MAX)) ? VAR_MAX : sum[VAR_W-1:0];
  endfunction

  // sq * 2^24 > thr_mult * var, done on the truncated product
  function automatic logic beyond_limit(logic [63:0] sq, logic [63:0] vr);
    logic [63:0] prod;
    prod = 64'(vfac_q8) * vr;
    return sq > (prod >> 24);
  endfunction

  function automatic mask_beat_t score_block(sad_beat_t b);
    mask_beat_t       r;
    logic [63:0]      sq, vr;
    logic [SAD_W-1:0] dmag;
    r.motion = 1'b0;
    r.ready  = stats_live;
    r.blk    = b.blk;
    r.last   = b.last;
    case (b.op)
      OP_UPDATE: begin
        n_update++;
        if (!stats_live) begin
          mean_mem[b.blk] = b.sad;
          var_mem[b.blk]  = {{(VAR_W - CFG_W){1'b0}}, init_var_q16};
          if (b.last) stats_live = 1'b1;
        end else begin
          sq = 64'(b.sad) * 64'(b.sad);
          vr = 64'(var_mem[b.blk]);
          if (!b.blink || ({1'b0, frames_done} + 6'd1) < 6'(WARMUP_FRAMES)) begin
            vr = 64'(ema_step(vr, sq));
            var_mem[b.blk] = vr[VAR_W-1:0];
          end else begin
            n_frozen++;
          end
          r.motion = beyond_limit(sq, vr);
        end
        if (b.last && frames_done != FC_MAX) frames_done++;
        if (int'(frames_done) > max_frames) max_frames = int'(frames_done);
      end
      OP_CLASSIFY: begin
        n_classify++;
        if (stats_live) begin
          dmag = (mean_mem[b.blk] > b.sad) ? mean_mem[b.blk] - b.sad : b.sad - mean_mem[b.blk];
          sq = 64'(dmag) * 64'(dmag);
          r.motion = beyond_limit(sq, 64'(var_mem[b.blk]));
        end
      end
      OP_RESTART: begin
        n_restart++;
        stats_live  = 1'b0;
        frames_done = '0;
      end
      default: n_ignored++;
    endcase
    return r;
  endfunction

  // monitor: score accepted input beats, check accepted result beats
  always @(posedge clk) begin
    if (!rst_n) begin
      beat_taken = 1'b0;
      out_taken  = 1'b0;
    end else begin
      beat_taken = in_valid && !in_stall;
      out_taken  = out_valid && !out_stall;
      if (out_taken) begin
        got_mask = '{out_motion_flag, out_stats_ready, out_block_out, out_frame_end};
        if (mask_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result beat: motion=%0b ready=%0b blk=%0d end=%0b",
                     got_mask.motion, got_mask.ready, got_mask.blk, got_mask.last);
        end else begin
          want_mask = mask_q.pop_front();
          if (got_mask.motion !== want_mask.motion || got_mask.ready !== want_mask.ready ||
              got_mask.blk !== want_mask.blk || got_mask.last !== want_mask.last) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display({"mismatch: expected motion=%0b ready=%0b blk=%0d end=%0b, ",
                        "got motion=%0b ready=%0b blk=%0d end=%0b"},
                       want_mask.motion, want_mask.ready, want_mask.blk, want_mask.last,
                       got_mask.motion, got_mask.ready, got_mask.blk, got_mask.last);
          end
          if (got_mask.motion === 1'b1) n_motion++;
        end
      end
      if (beat_taken)
        mask_q.push_back(score_block('{in_operation, in_block_index, in_sad_value,
                                       in_blink_active, in_last_block, 3'd0}));
    end
  end

  // driver: next beat goes out once its gap has elapsed
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || beat_taken) begin
      if (sad_q.size() != 0 && gap_wait >= int'(sad_q[0].gap)) begin
        drv_beat = sad_q.pop_front();
        gap_wait = 0;
        in_operation    <= drv_beat.op;
        in_block_index  <= drv_beat.blk;
        in_sad_value    <= drv_beat.sad;
        in_blink_active <= drv_beat.blink;
        in_last_block   <= drv_beat.last;
        in_valid        <= 1'b1;
      end else begin
        in_valid <= 1'b0;
        if (sad_q.size() != 0) gap_wait++;
      end
    end
  end

  // result side backpressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_taken) begin
        stall_left = sink_burst ? 0 : int'($urandom_range(0, 7));
        if ($urandom_range(0, 99) < 3) sink_burst = !sink_burst;
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [SAD_W-1:0] rand_sad();
    int r;
    r = int'($urandom_range(0, 9));
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 4) return SAD_W'($urandom_range(0, 255));
    return SAD_W'($urandom);
  endfunction

  function automatic logic [BLK_W-1:0] pick_written();
    return written_list[$urandom_range(0, written_list.size() - 1)];
  endfunction

  task automatic push_item(input logic [1:0] op, input logic [BLK_W-1:0] blk,
                           input logic [SAD_W-1:0] sad, input logic blink, input logic last);
    sad_beat_t b;
    while (sad_q.size() >= 16) @(posedge clk);
    b = '{op, blk, sad, blink, last, 3'd0};
    b.gap = src_burst ? 3'd0 : 3'($urandom_range(0, 7));
    if ($urandom_range(0, 99) < 3) src_burst = !src_burst;
    sad_q.push_back(b);
    if (op == OP_UPDATE && !gen_live) begin
      if (!gen_written[blk]) begin
        gen_written[blk] = 1'b1;
        written_list.push_back(blk);
      end
      if (last) gen_live = 1'b1;
    end else if (op == OP_RESTART) begin
      gen_live = 1'b0;
    end
    if (op != OP_UNUSED) gen_count++;
  endtask

  // optional restart, a seeding frame, then a few or many frames of update and classify
  task automatic send_run();
    int               n_first, n_frames, per_frame, r;
    logic             frame_blink;
    logic [1:0]       op;
    logic [BLK_W-1:0] blk;
    if (gen_live || $urandom_range(0, 1))
      push_item(OP_RESTART, BLK_W'($urandom), rand_sad(), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    n_first = int'($urandom_range(1, 6));
    for (int i = 0; i < n_first; i++) begin
      blk = BLK_W'($urandom);
      if (written_list.size() != 0 && $urandom_range(0, 9) < 4) blk = pick_written();
      push_item(OP_UPDATE, blk, rand_sad(), 1'($urandom_range(0, 1)), i == n_first - 1);
    end
    n_frames = ($urandom_range(0, 2) == 0) ? int'($urandom_range(30, 34))
                                           : int'($urandom_range(1, 6));
    for (int f = 0; f < n_frames; f++) begin
      frame_blink = ($urandom_range(0, 2) == 0);
      per_frame   = int'($urandom_range(1, 3));
      for (int k = 0; k < per_frame - 1; k++) begin
        r  = int'($urandom_range(0, 19));
        op = (r < 12) ? OP_UPDATE : (r < 18) ? OP_CLASSIFY : OP_UNUSED;
        push_item(op, pick_written(), rand_sad(), frame_blink ^ ($urandom_range(0, 9) == 0),
                  op == OP_CLASSIFY && $urandom_range(0, 9) == 0);
      end
      push_item(OP_UPDATE, pick_written(), rand_sad(), frame_blink, 1'b1);
    end
  endtask

  task automatic send_noise();
    logic [1:0]       op;
    logic [BLK_W-1:0] blk;
    op  = 2'($urandom_range(0, 3));
    blk = BLK_W'($urandom);
    if (gen_live && (op == OP_UPDATE || op == OP_CLASSIFY)) blk = pick_written();
    push_item(op, blk, rand_sad(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic drain_all();
    while (sad_q.size() != 0 || in_valid || mask_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_RHO:      rho_q16      = val;
      CFG_INIT_VAR: init_var_q16 = val;
      CFG_THR_MULT: vfac_q8      = val;
      default: ;
    endcase
  endtask

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, mask_q.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [CFG_W-1:0] rv, iv, fv;
    int               target;
    bit               paused;
    paused = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // classify and ignored op with no statistics, then a seeding frame at the field extremes
    push_item(OP_CLASSIFY, 10'd0, 16'd0, 1'b0, 1'b0);
    push_item(OP_UNUSED, 10'd1023, 16'hFFFF, 1'b1, 1'b1);
    push_item(OP_RESTART, 10'd5, 16'd0, 1'b0, 1'b0);
    push_item(OP_UPDATE, 10'd0, 16'd0, 1'b0, 1'b0);
    push_item(OP_UPDATE, 10'd1023, 16'hFFFF, 1'b1, 1'b0);
    push_item(OP_UPDATE, 10'd341, 16'h5555, 1'b0, 1'b0);
    push_item(OP_UPDATE, 10'd682, 16'hAAAA, 1'b1, 1'b1);
    // largest and zero distance from the stored mean
    push_item(OP_CLASSIFY, 10'd0, 16'hFFFF, 1'b0, 1'b0);
    push_item(OP_CLASSIFY, 10'd1023, 16'hFFFF, 1'b0, 1'b0);
    push_item(OP_UPDATE, 10'd1023, 16'hFFFF, 1'b0, 1'b0);
    // blink inside warm-up still updates
    push_item(OP_UPDATE, 10'd0, 16'd0, 1'b1, 1'b0);
    push_item(OP_UPDATE, 10'd341, 16'd0, 1'b0, 1'b0);
    // last on a classify or an ignored op does not close the frame
    push_item(OP_CLASSIFY, 10'd682, 16'd0, 1'b0, 1'b1);
    push_item(OP_UNUSED, 10'd682, 16'd0, 1'b0, 1'b1);
    push_item(OP_UPDATE, 10'd682, 16'hFFFF, 1'b0, 1'b1);
    push_item(OP_RESTART, 10'd0, 16'hFFFF, 1'b1, 1'b1);
    push_item(OP_CLASSIFY, 10'd341, 16'd1, 1'b0, 1'b0);
    push_item(OP_UPDATE, 10'd341, 16'd1, 1'b0, 1'b1);
    push_item(OP_UPDATE, 10'd341, 16'hFFFF, 1'b0, 1'b1);
    drain_all();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin rv = '0; iv = '0; fv = '0; end
        1:       begin rv = '1; iv = '1; fv = '1; end
        2:       begin rv = '1; iv = '0; fv = 16'd1; end
        3:       begin rv = 16'd1; iv = '1; fv = THR_MULT_RST; end
        default: begin
          rv = CFG_W'($urandom);
          iv = CFG_W'($urandom);
          fv = CFG_W'($urandom_range(0, 1023));
        end
      endcase
      write_reg(CFG_RHO, rv);
      write_reg(CFG_INIT_VAR, iv);
      write_reg(CFG_THR_MULT, fv);
      target = gen_count + PHASE_ITEMS;
      while (gen_count < target) begin
        // in phase 2 the sender holds off mid-phase until every result is back
        if (ph == 2 && !paused && gen_count >= target - PHASE_ITEMS / 2) begin
          drain_all();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) < 8) send_run();
        else repeat ($urandom_range(1, 4)) send_noise();
      end
      drain_all();
    end

    $display("covered %0d update, %0d classify, %0d restart and %0d ignored beats",
             n_update, n_classify, n_restart, n_ignored);
    $display("%0d motion flags, %0d blink-held variance updates, frame count up to %0d",
             n_motion, n_frozen, max_frames);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
